/* rtl/fdmc_pkg.sv */
package fdmc_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 19;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FRAME_WIDTH    = 3'd0,
      CSR_FRAME_HEIGHT   = 3'd1,
      CSR_DIFF_THRESHOLD = 3'd2,
      CSR_MIN_MOVING     = 3'd3,
      CSR_SMOOTHING_KEEP = 3'd4
   } csr_index_type;

   localparam logic [9:0]  RST_FRAME_WIDTH    = 10'd320;
   localparam logic [9:0]  RST_FRAME_HEIGHT   = 10'd240;
   localparam logic [7:0]  RST_DIFF_THRESHOLD = 8'd50;
   localparam logic [18:0] RST_MIN_MOVING     = 19'd100;
   localparam logic [8:0]  RST_SMOOTHING_KEEP = 9'd205;

   localparam int DIM_W = 13;
   localparam int RSP_DATA_W = 56;

endpackage

/* rtl/frame_difference_motion_centroid.sv */
// Motion centroid tracker: one gray pixel per transaction in raster order. The previous
// frame lives in a MAX_WIDTH*MAX_HEIGHT byte memory that is read and rewritten for every
// pixel, so pixels stream at one per clock. At the last pixel of every frame after the
// first the input stalls while a shared radix-2 divider (one quotient bit per clock) forms
// the centroid, when the position updates, and the normalized position on dividends of
// DIVW bits (36 bits for the default size); the stall also lasts while the previous result
// is not yet taken. One result transaction per frame after the first.
module frame_difference_motion_centroid
   import fdmc_pkg::*;
#(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // pixel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // goal_x, goal_y, moving_count, position_updated
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int COLW   = $clog2(MAX_WIDTH);
   localparam int ROWW   = $clog2(MAX_HEIGHT);
   localparam int ADDRW  = $clog2(DEPTH);
   localparam int CNTW   = $clog2(DEPTH + 1);
   localparam int CMPW   = (CNTW > 19) ? CNTW : 19;
   localparam int CSUMW  = CNTW + COLW;
   localparam int RSUMW  = CNTW + ROWW;
   localparam int SUMW   = (CSUMW > RSUMW) ? CSUMW : RSUMW;
   localparam int SMXW   = COLW + 8;
   localparam int SMYW   = ROWW + 8;
   localparam int SMW    = (SMXW > SMYW) ? SMXW : SMYW;
   localparam int DIVA   = SUMW + 8;
   localparam int DIVB   = SMW + 8;
   localparam int DIVW0  = (DIVA > DIVB) ? DIVA : DIVB;
   localparam int DIVW   = (DIVW0 > 17) ? DIVW0 : 17;
   localparam int DENW   = (CNTW > DIM_W) ? CNTW : DIM_W;
   localparam int DCW    = $clog2(DIVW + 1);
   localparam int PRODW  = SMW + 9;

   typedef enum logic [3:0] {
      S_IDLE, S_FLUSH, S_DECIDE, S_DIV_CX, S_DIV_CY, S_MUL, S_SUM,
      S_DIV_GX, S_DIV_GY, S_OUT
   } state_type;

   logic [9:0]  frame_width_ff, frame_height_ff;
   logic [7:0]  diff_threshold_ff;
   logic [18:0] min_moving_ff;
   logic [8:0]  smoothing_keep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= RST_FRAME_WIDTH;
         frame_height_ff   <= RST_FRAME_HEIGHT;
         diff_threshold_ff <= RST_DIFF_THRESHOLD;
         min_moving_ff     <= RST_MIN_MOVING;
         smoothing_keep_ff <= RST_SMOOTHING_KEEP;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FRAME_WIDTH:    frame_width_ff    <= csr_wdata[9:0];
            CSR_FRAME_HEIGHT:   frame_height_ff   <= csr_wdata[9:0];
            CSR_DIFF_THRESHOLD: diff_threshold_ff <= csr_wdata[7:0];
            CSR_MIN_MOVING:     min_moving_ff     <= csr_wdata;
            CSR_SMOOTHING_KEEP: smoothing_keep_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   logic [DIM_W-1:0] w_eff, h_eff;
   logic [8:0]       keep;

   always_comb begin
      if (frame_width_ff == '0) w_eff = DIM_W'(1);
      else if (DIM_W'(frame_width_ff) > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
      else w_eff = DIM_W'(frame_width_ff);
      if (frame_height_ff == '0) h_eff = DIM_W'(1);
      else if (DIM_W'(frame_height_ff) > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
      else h_eff = DIM_W'(frame_height_ff);
      keep = (smoothing_keep_ff > 9'd256) ? 9'd256 : smoothing_keep_ff;
   end

   state_type state_ff;
   logic      have_prev_ff;
   logic [COLW-1:0] col_ff;
   logic [ROWW-1:0] row_ff;

   logic accept, end_row, end_frame;
   logic [ADDRW-1:0] addr;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign end_row    = DIM_W'(col_ff) >= (w_eff - DIM_W'(1));
   assign end_frame  = end_row && (DIM_W'(row_ff) >= (h_eff - DIM_W'(1)));
   assign addr       = ADDRW'(row_ff) * ADDRW'(MAX_WIDTH) + ADDRW'(col_ff);

   logic [7:0] mem [DEPTH];
   logic [7:0] prev_pix_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         prev_pix_ff <= mem[addr];
         mem[addr]   <= req_tdata;
      end
   end

   logic            s1_valid_ff, s1_check_ff;
   logic [7:0]      s1_pix_ff;
   logic [COLW-1:0] s1_col_ff;
   logic [ROWW-1:0] s1_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_check_ff <= have_prev_ff;
         s1_pix_ff   <= req_tdata;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
      end
   end

   logic [7:0] abs_diff;
   logic       moving;
   assign abs_diff = (s1_pix_ff > prev_pix_ff) ? s1_pix_ff - prev_pix_ff
                                               : prev_pix_ff - s1_pix_ff;
   assign moving   = s1_valid_ff && s1_check_ff && (abs_diff > diff_threshold_ff);

   logic [CNTW-1:0]  total_ff;
   logic [CSUMW-1:0] csum_ff;
   logic [RSUMW-1:0] rsum_ff;
   logic             acc_clear;

   always_ff @(posedge clock) begin
      if (reset || acc_clear) begin
         total_ff <= '0;
         csum_ff  <= '0;
         rsum_ff  <= '0;
      end else if (moving) begin
         total_ff <= total_ff + CNTW'(1);
         csum_ff  <= csum_ff + CSUMW'(s1_col_ff);
         rsum_ff  <= rsum_ff + RSUMW'(s1_row_ff);
      end
   end

   logic            div_busy_ff;
   logic [DCW-1:0]  div_cnt_ff;
   logic [DIVW-1:0] div_quo_ff;
   logic [DENW:0]   div_rem_ff;
   logic [DENW-1:0] div_den_ff;
   logic [DIVW-1:0] div_num;
   logic [DENW-1:0] div_den;
   logic [DENW:0]   rem_shift;
   logic            rem_ge;

   logic [SMXW-1:0] sx_ff;
   logic [SMYW-1:0] sy_ff;
   logic [SMXW-1:0] cx_ff;
   logic [SMYW-1:0] cy_ff;
   logic [PRODW-1:0] px_old_ff, px_new_ff, py_old_ff, py_new_ff;
   logic            upd_ff;
   logic [DIVW-1:0] qx_ff;
   logic [15:0]     goal_x, goal_y;
   logic [17:0]     gy_wide;

   logic            rsp_valid_ff;
   logic [15:0]     rsp_gx_ff, rsp_gy_ff;
   logic [18:0]     rsp_count_ff;
   logic            rsp_upd_ff;
   logic            out_free;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign acc_clear = (state_ff == S_OUT) && out_free;

   always_comb begin
      case (state_ff)
         S_DIV_CX: begin
            div_num = DIVW'({csum_ff, 8'd0});
            div_den = DENW'(total_ff);
         end
         S_DIV_CY: begin
            div_num = DIVW'({rsum_ff, 8'd0});
            div_den = DENW'(total_ff);
         end
         S_DIV_GX: begin
            div_num = DIVW'({sx_ff, 8'd0});
            div_den = DENW'(w_eff);
         end
         S_DIV_GY: begin
            div_num = DIVW'({sy_ff, 8'd0});
            div_den = DENW'(h_eff);
         end
         default: begin
            div_num = '0;
            div_den = DENW'(1);
         end
      endcase
      rem_shift = {div_rem_ff[DENW-1:0], div_quo_ff[DIVW-1]};
      rem_ge    = rem_shift >= {1'b0, div_den_ff};
   end

   always_comb begin
      if (qx_ff > DIVW'(65535)) goal_x = 16'h7fff;
      else goal_x = {~qx_ff[15], qx_ff[14:0]};
      gy_wide = 18'd32768 - {1'b0, div_quo_ff[16:0]};
      if (div_quo_ff == '0) goal_y = 16'h7fff;
      else if (div_quo_ff > DIVW'(65536)) goal_y = 16'h8000;
      else goal_y = gy_wide[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         have_prev_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         div_busy_ff  <= 1'b0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !acc_clear) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (end_row) begin
                     col_ff <= '0;
                     row_ff <= end_frame ? '0 : row_ff + ROWW'(1);
                  end else begin
                     col_ff <= col_ff + COLW'(1);
                  end
                  if (end_frame) begin
                     if (have_prev_ff) begin
                        state_ff <= S_FLUSH;
                     end else begin
                        have_prev_ff <= 1'b1;
                     end
                  end
               end
            end
            S_FLUSH: begin
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               upd_ff   <= CMPW'(total_ff) > CMPW'(min_moving_ff);
               state_ff <= (CMPW'(total_ff) > CMPW'(min_moving_ff)) ? S_DIV_CX : S_DIV_GX;
            end
            S_DIV_CX, S_DIV_CY, S_DIV_GX, S_DIV_GY: begin
               if (!div_busy_ff) begin
                  div_busy_ff <= 1'b1;
                  div_cnt_ff  <= DCW'(DIVW);
                  div_quo_ff  <= div_num;
                  div_rem_ff  <= '0;
                  div_den_ff  <= div_den;
               end else if (div_cnt_ff != '0) begin
                  div_cnt_ff <= div_cnt_ff - DCW'(1);
                  div_quo_ff <= {div_quo_ff[DIVW-2:0], rem_ge};
                  div_rem_ff <= rem_ge ? rem_shift - {1'b0, div_den_ff} : rem_shift;
               end else begin
                  div_busy_ff <= 1'b0;
                  case (state_ff)
                     S_DIV_CX: begin
                        cx_ff    <= SMXW'(div_quo_ff);
                        state_ff <= S_DIV_CY;
                     end
                     S_DIV_CY: begin
                        cy_ff    <= SMYW'(div_quo_ff);
                        state_ff <= S_MUL;
                     end
                     S_DIV_GX: begin
                        qx_ff    <= div_quo_ff;
                        state_ff <= S_DIV_GY;
                     end
                     default: begin
                        state_ff <= S_OUT;
                     end
                  endcase
               end
            end
            S_MUL: begin
               px_old_ff <= PRODW'(keep) * PRODW'(sx_ff);
               px_new_ff <= PRODW'(9'd256 - keep) * PRODW'(cx_ff);
               py_old_ff <= PRODW'(keep) * PRODW'(sy_ff);
               py_new_ff <= PRODW'(9'd256 - keep) * PRODW'(cy_ff);
               state_ff  <= S_SUM;
            end
            S_SUM: begin
               sx_ff    <= SMXW'(({1'b0, px_old_ff} + {1'b0, px_new_ff}
                                  + (PRODW + 1)'(128)) >> 8);
               sy_ff    <= SMYW'(({1'b0, py_old_ff} + {1'b0, py_new_ff}
                                  + (PRODW + 1)'(128)) >> 8);
               state_ff <= S_DIV_GX;
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_gx_ff    <= goal_x;
                  rsp_gy_ff    <= goal_y;
                  rsp_count_ff <= 19'(total_ff);
                  rsp_upd_ff   <= upd_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_upd_ff, rsp_count_ff, rsp_gy_ff, rsp_gx_ff};

endmodule

/* dv/tb_top.sv */
module tb_top;
   import fdmc_pkg::*;

   typedef struct packed {
      logic [15:0] goal_x;
      logic [15:0] goal_y;
      logic [18:0] moving_count;
      logic        position_updated;
   } centroid_result_type;

   localparam int MAX_W = 512;
   localparam int MAX_H = 512;
   localparam int PRIME_W = 8;
   localparam int PRIME_H = 4;
   localparam int ITEM_TARGET = 650;
   localparam int SETTLE_CYCLES = 200;
   localparam int STALL_LIMIT = 20000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   frame_difference_motion_centroid DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Tracker state as predicted.
   logic [7:0]         stored_frame [MAX_W*MAX_H];
   bit                 seen_frame;
   int unsigned        col_pos, row_pos;
   longint unsigned    moving_pixels, col_total, row_total, pos_x, pos_y;
   logic [9:0]         cfg_width, cfg_height;
   logic [7:0]         cfg_threshold;
   logic [18:0]        cfg_min_moving;
   logic [8:0]         cfg_keep;

   centroid_result_type pending_results [$];
   int                 errors = 0;
   int                 items_sent = 0;
   bit                 sender_bursty = 1'b0;
   bit                 receiver_bursty = 1'b0;
   int                 stall_cycles = 0;

   function automatic longint unsigned fold_position(longint unsigned prev_pos,
         longint unsigned total, longint unsigned count, longint unsigned keep);
      longint unsigned centroid;
      centroid = (total << 8) / count;
      return (keep * prev_pos + (256 - keep) * centroid + 128) >> 8;
   endfunction

   function automatic logic [15:0] saturate_q15(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic int unsigned clamp_size(logic [9:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic bit track_pixel(input logic [7:0] pix, output centroid_result_type r);
      int unsigned w, h, addr, d;
      bit row_done, frame_done, upd;
      longint unsigned keep;
      w = clamp_size(cfg_width, MAX_W);
      h = clamp_size(cfg_height, MAX_H);
      addr = row_pos * MAX_W + col_pos;
      r = '0;
      if (seen_frame) begin
         d = (pix > stored_frame[addr]) ? pix - stored_frame[addr] : stored_frame[addr] - pix;
         if (d > cfg_threshold) begin
            moving_pixels++;
            col_total += col_pos;
            row_total += row_pos;
         end
      end
      stored_frame[addr] = pix;
      row_done = col_pos >= w - 1;
      frame_done = row_done && row_pos >= h - 1;
      if (row_done) begin
         col_pos = 0;
         row_pos = frame_done ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
      if (!frame_done) return 1'b0;
      if (!seen_frame) begin
         seen_frame = 1'b1;
         moving_pixels = 0; col_total = 0; row_total = 0;
         return 1'b0;
      end
      keep = (cfg_keep > 256) ? 256 : cfg_keep;
      upd = moving_pixels > cfg_min_moving;
      if (upd) begin
         pos_x = fold_position(pos_x, col_total, moving_pixels, keep);
         pos_y = fold_position(pos_y, row_total, moving_pixels, keep);
      end
      r.goal_x = saturate_q15(longint'((pos_x << 8) / w) - 32768);
      r.goal_y = saturate_q15(32768 - longint'((pos_y << 8) / h));
      r.moving_count = moving_pixels[18:0];
      r.position_updated = upd;
      moving_pixels = 0; col_total = 0; row_total = 0;
      return 1'b1;
   endfunction

   task automatic write_csr(csr_index_type idx, int unsigned value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = value[CSR_DATA_W-1:0];
      case (idx)
         CSR_FRAME_WIDTH:    cfg_width = value[9:0];
         CSR_FRAME_HEIGHT:   cfg_height = value[9:0];
         CSR_DIFF_THRESHOLD: cfg_threshold = value[7:0];
         CSR_MIN_MOVING:     cfg_min_moving = value[18:0];
         CSR_SMOOTHING_KEEP: cfg_keep = value[8:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic send_pixel(logic [7:0] pix);
      int gap;
      centroid_result_type r;
      gap = sender_bursty ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (track_pixel(pix, r)) pending_results.push_back(r);
      @(negedge clock);
   endtask

   // Lets the block finish its frame-end work so registers change only while it is idle.
   task automatic drain();
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(int unsigned w, int unsigned h, int unsigned thr,
         int unsigned minm, int unsigned keep);
      drain();
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
      write_csr(CSR_DIFF_THRESHOLD, thr);
      write_csr(CSR_MIN_MOVING, minm);
      write_csr(CSR_SMOOTHING_KEEP, keep);
   endtask

   function automatic int unsigned frame_pixels();
      return clamp_size(cfg_width, MAX_W) * clamp_size(cfg_height, MAX_H);
   endfunction

   // Mostly small changes from the stored frame so that counts land near the minimum.
   function automatic logic [7:0] next_pixel();
      int v;
      if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 255));
      v = stored_frame[row_pos * MAX_W + col_pos] + $urandom_range(0, 40) - 20;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   task automatic send_random_frame();
      int unsigned n;
      n = frame_pixels();
      for (int unsigned i = 0; i < n; i++) send_pixel(next_pixel());
   endtask

   // The first frame writes every stored pixel that any later frame size reads.
   task automatic test_prime_frame();
      configure(PRIME_W, PRIME_H, RST_DIFF_THRESHOLD, RST_MIN_MOVING, RST_SMOOTHING_KEEP);
      for (int i = 0; i < PRIME_W * PRIME_H; i++) send_pixel(8'($urandom_range(0, 255)));
   endtask

   task automatic test_directed();
      configure(2, 2, 0, 0, 0);
      send_pixel(8'd0); send_pixel(8'd255); send_pixel(8'd0); send_pixel(8'd255);
      send_pixel(8'd255); send_pixel(8'd0); send_pixel(8'd255); send_pixel(8'd0);
      configure(2, 2, 255, 0, 256);
      send_pixel(8'd0); send_pixel(8'd255); send_pixel(8'd0); send_pixel(8'd255);
      configure(0, 0, 0, 262144, 511);
      send_pixel(8'd255); send_pixel(8'd0); send_pixel(8'd128);
      configure(1, 2, 10, 0, 128);
      send_pixel(8'd0); send_pixel(8'd200); send_pixel(8'd255); send_pixel(8'd0);
      configure(3, 1, 1, 1, 205);
      send_pixel(8'd0); send_pixel(8'd0); send_pixel(8'd255);
   endtask

   task automatic test_size_extremes();
      configure(0, PRIME_H, 20, 0, 0);
      send_random_frame();
      configure(PRIME_W, 0, 20, 3, 64);
      send_random_frame();
      configure(1, PRIME_H, 20, 0, 256);
      send_random_frame();
   endtask

   task automatic test_random();
      int unsigned w, h;
      while (items_sent < ITEM_TARGET) begin
         w = $urandom_range(0, PRIME_W);
         h = $urandom_range(0, PRIME_H);
         configure(w, h, ($urandom_range(0, 1) == 0) ? $urandom_range(0, 30) :
                   $urandom_range(0, 255),
                   ($urandom_range(0, 7) == 0) ? $urandom_range(0, 262144) :
                   $urandom_range(0, 6), $urandom_range(0, 511));
         sender_bursty = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) begin
            send_random_frame();
         end
      end
      sender_bursty = 1'b0;
   endtask

   initial begin
      forever begin
         int gap;
         centroid_result_type want;
         gap = receiver_bursty ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[15:0] !== want.goal_x) begin
               $display("%0t: goal_x expected %h actual %h", $time, want.goal_x,
                        rsp_tdata[15:0]);
               errors++;
            end
            if (rsp_tdata[31:16] !== want.goal_y) begin
               $display("%0t: goal_y expected %h actual %h", $time, want.goal_y,
                        rsp_tdata[31:16]);
               errors++;
            end
            if (rsp_tdata[50:32] !== want.moving_count) begin
               $display("%0t: moving_count expected %0d actual %0d", $time,
                        want.moving_count, rsp_tdata[50:32]);
               errors++;
            end
            if (rsp_tdata[51] !== want.position_updated) begin
               $display("%0t: position_updated expected %b actual %b", $time,
                        want.position_updated, rsp_tdata[51]);
               errors++;
            end
         end
         if ($urandom_range(0, 7) == 0) receiver_bursty = ~receiver_bursty;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      seen_frame = 1'b0;
      col_pos = 0; row_pos = 0;
      moving_pixels = 0; col_total = 0; row_total = 0; pos_x = 0; pos_y = 0;
      cfg_width = RST_FRAME_WIDTH;
      cfg_height = RST_FRAME_HEIGHT;
      cfg_threshold = RST_DIFF_THRESHOLD;
      cfg_min_moving = RST_MIN_MOVING;
      cfg_keep = RST_SMOOTHING_KEEP;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_prime_frame();
      test_directed();
      test_size_extremes();
      test_random();
      drain();
      if (errors == 0 && pending_results.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/fdmc_pkg.sv
rtl/frame_difference_motion_centroid.sv
dv/tb_top.sv
